// ===== design/triangle_edge_rasterizer_core_defines.svh =====
// assertion macros used by the rasterizer back part
// depends on: a clk and an active-high rst in the module that uses them
`ifndef TRIANGLE_EDGE_RASTERIZER_CORE_DEFINES_SVH
`define TRIANGLE_EDGE_RASTERIZER_CORE_DEFINES_SVH

// property checked at every rising clock edge outside reset
`define TER_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// condition that must hold in the cycle after a trigger
`define TER_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ter_pkg.sv =====
// shared types, widths and helpers for the triangle rasterizer
// depends on: nothing
package ter_pkg;

  // coordinate and arithmetic widths
  localparam int COORD_BITS  = 14;
  localparam int SCREEN_BITS = 13;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int PROD_BITS   = 2 * DIFF_BITS;
  localparam int EDGE_BITS   = PROD_BITS + 1;
  localparam int CMP_BITS    = ((COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS) + 1;

  // queue sizing
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // register map
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [EDGE_BITS-1:0]  edge_t;
  typedef logic [SCREEN_BITS-1:0]       screen_t;
  typedef logic [QPTR_BITS-1:0]         qptr_t;
  typedef logic [QCNT_BITS-1:0]         qcnt_t;

  typedef enum logic [0:0] {
    OP_LOAD    = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_idx_t;

  // classified command item from front to back
  typedef struct packed {
    op_t    op;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t cx;
    coord_t cy;
  } cmd_t;

  // result item from back to the result queue
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   covered;
    logic   last_pixel;
  } res_t;

  // sign-extended difference of two coordinates
  function automatic diff_t coord_diff(coord_t a, coord_t b);
    return DIFF_BITS'(a) - DIFF_BITS'(b);
  endfunction

  // queue pointer advance with wrap
  function automatic qptr_t qptr_inc(qptr_t p);
    return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ===== design/ter_front.sv =====
// front part: accepts command items, classifies them and queues them
// depends on: ter_pkg
module ter_front
  import ter_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  output logic   full,
  input  logic   command,
  input  coord_t vertex_a_x,
  input  coord_t vertex_a_y,
  input  coord_t vertex_b_x,
  input  coord_t vertex_b_y,
  input  coord_t vertex_c_x,
  input  coord_t vertex_c_y,
  output logic   cmd_valid,
  output cmd_t   cmd,
  input  logic   cmd_pop
);

  cmd_t  entries [QUEUE_DEPTH];
  qptr_t wr_ptr;
  qptr_t rd_ptr;
  qcnt_t count;
  logic  wr_en;
  logic  rd_en;
  cmd_t  incoming;

  // classify the incoming item
  always_comb begin
    incoming.op = op_t'(command);
    incoming.ax = vertex_a_x;
    incoming.ay = vertex_a_y;
    incoming.bx = vertex_b_x;
    incoming.by = vertex_b_y;
    incoming.cx = vertex_c_x;
    incoming.cy = vertex_c_y;
  end

  assign full      = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign wr_en     = push && !full;
  assign rd_en     = cmd_pop && cmd_valid;
  assign cmd       = entries[rd_ptr];

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= qptr_inc(wr_ptr);
      if (rd_en) rd_ptr <= qptr_inc(rd_ptr);
      if (wr_en && !rd_en) count <= count + 1'b1;
      else if (!wr_en && rd_en) count <= count - 1'b1;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) entries[wr_ptr] <= incoming;
  end

endmodule

// ===== design/ter_back.sv =====
// back part: triangle setup and the pixel walk with edge-function tests
// depends on: ter_pkg, triangle_edge_rasterizer_core_defines.svh
`include "triangle_edge_rasterizer_core_defines.svh"

module ter_back
  import ter_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    cmd_pop,
  input  screen_t screen_width,
  input  screen_t screen_height,
  input  logic    res_full,
  output logic    res_push,
  output res_t    res
);

  typedef enum logic [2:0] {
    S_IDLE     = 3'b001,
    S_LOAD_FIN = 3'b010,
    S_ADV_FIN  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // triangle store
  coord_t ax, ay, bx, by, cx, cy;
  coord_t box_min_x, box_max_x, box_min_y, box_max_y;
  coord_t walk_x, walk_y;
  logic   ccw;
  logic   walk_active;

  // registered edge products
  prod_t pa [3];
  prod_t pb [3];
  prod_t pa_next [3];
  prod_t pb_next [3];

  logic  load_go;
  logic  adv_go;
  edge_t e0, e1, e2;
  edge_t area;
  logic  in_tri;
  logic  on_screen;
  logic  last;
  logic signed [CMP_BITS-1:0] x_cmp, y_cmp, w_cmp, h_cmp;
  coord_t e0_sx, e0_sy, e0_ex, e0_ey, e0_px, e0_py;

  function automatic coord_t min3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic coord_t max3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // issue control
  always_comb begin
    cmd_pop    = 1'b0;
    load_go    = 1'b0;
    adv_go     = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == OP_LOAD) begin
            cmd_pop    = 1'b1;
            load_go    = 1'b1;
            state_next = S_LOAD_FIN;
          end else if (!walk_active) begin
            // advance with no walk: dropped
            cmd_pop = 1'b1;
          end else if (!res_full) begin
            cmd_pop    = 1'b1;
            adv_go     = 1'b1;
            state_next = S_ADV_FIN;
          end
        end
      end
      S_LOAD_FIN: state_next = S_IDLE;
      S_ADV_FIN:  state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // edge a->b is shared: area at vertex c on load, coverage at the walk point on advance
  always_comb begin
    e0_sx = load_go ? cmd.ax : ax;
    e0_sy = load_go ? cmd.ay : ay;
    e0_ex = load_go ? cmd.bx : bx;
    e0_ey = load_go ? cmd.by : by;
    e0_px = load_go ? cmd.cx : walk_x;
    e0_py = load_go ? cmd.cy : walk_y;
    pa_next[0] = coord_diff(e0_px, e0_sx) * coord_diff(e0_ey, e0_sy);
    pb_next[0] = coord_diff(e0_py, e0_sy) * coord_diff(e0_ex, e0_sx);
    pa_next[1] = coord_diff(walk_x, bx) * coord_diff(cy, by);
    pb_next[1] = coord_diff(walk_y, by) * coord_diff(cx, bx);
    pa_next[2] = coord_diff(walk_x, cx) * coord_diff(ay, cy);
    pb_next[2] = coord_diff(walk_y, cy) * coord_diff(ax, cx);
  end

  // product stage
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pa[i] <= pa_next[i];
      pb[i] <= pb_next[i];
    end
  end

  // edge values, coverage and end-of-box test
  always_comb begin
    e0   = EDGE_BITS'(pa[0]) - EDGE_BITS'(pb[0]);
    e1   = EDGE_BITS'(pa[1]) - EDGE_BITS'(pb[1]);
    e2   = EDGE_BITS'(pa[2]) - EDGE_BITS'(pb[2]);
    area = e0;
    if (ccw) in_tri = !e0[EDGE_BITS-1] && !e1[EDGE_BITS-1] && !e2[EDGE_BITS-1];
    else     in_tri = (e0 <= 0) && (e1 <= 0) && (e2 <= 0);
    x_cmp     = CMP_BITS'(walk_x);
    y_cmp     = CMP_BITS'(walk_y);
    w_cmp     = $signed(CMP_BITS'(screen_width));
    h_cmp     = $signed(CMP_BITS'(screen_height));
    on_screen = !x_cmp[CMP_BITS-1] && !y_cmp[CMP_BITS-1] && (x_cmp < w_cmp) && (y_cmp < h_cmp);
    last      = (walk_x == box_max_x) && (walk_y == box_max_y);
  end

  assign res_push       = (state == S_ADV_FIN);
  assign res.pixel_x    = walk_x;
  assign res.pixel_y    = walk_y;
  assign res.covered    = in_tri && on_screen;
  assign res.last_pixel = last;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      walk_active <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_LOAD_FIN) walk_active <= (area != 0);
      else if (state == S_ADV_FIN && last) walk_active <= 1'b0;
    end
  end

  // triangle setup and walk position
  always_ff @(posedge clk) begin
    if (load_go) begin
      ax        <= cmd.ax;
      ay        <= cmd.ay;
      bx        <= cmd.bx;
      by        <= cmd.by;
      cx        <= cmd.cx;
      cy        <= cmd.cy;
      box_min_x <= min3(cmd.ax, cmd.bx, cmd.cx);
      box_max_x <= max3(cmd.ax, cmd.bx, cmd.cx);
      box_min_y <= min3(cmd.ay, cmd.by, cmd.cy);
      box_max_y <= max3(cmd.ay, cmd.by, cmd.cy);
    end
    if (state == S_LOAD_FIN) begin
      ccw    <= (area > 0);
      walk_x <= box_min_x;
      walk_y <= box_min_y;
    end else if (state == S_ADV_FIN && !last) begin
      if (walk_x < box_max_x) begin
        walk_x <= walk_x + 1'b1;
      end else begin
        walk_x <= box_min_x;
        walk_y <= walk_y + 1'b1;
      end
    end
  end

  `TER_ASSERT(a_push_has_room, !(res_push && res_full), "result pushed into a full queue")
  `TER_ASSERT(a_pop_has_item, !(cmd_pop && !cmd_valid), "command popped from an empty queue")
  `TER_ASSERT(a_adv_needs_walk, (state == S_ADV_FIN) |-> walk_active, "pixel without active walk")
  `TER_ASSERT_NEXT(a_walk_starts_at_corner, state == S_LOAD_FIN,
    (walk_x == box_min_x) && (walk_y == box_min_y), "walk does not start at box corner")

endmodule

// ===== design/ter_resq.sv =====
// result queue between the back part and the receiver
// depends on: ter_pkg
module ter_resq
  import ter_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic res_push,
  input  res_t res_in,
  output logic res_full,
  output logic empty,
  input  logic pop,
  output res_t res_out
);

  res_t  entries [QUEUE_DEPTH];
  qptr_t wr_ptr;
  qptr_t rd_ptr;
  qcnt_t count;
  logic  wr_en;
  logic  rd_en;

  assign res_full = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign wr_en    = res_push && !res_full;
  assign rd_en    = pop && !empty;
  assign res_out  = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= qptr_inc(wr_ptr);
      if (rd_en) rd_ptr <= qptr_inc(rd_ptr);
      if (wr_en && !rd_en) count <= count + 1'b1;
      else if (!wr_en && rd_en) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) entries[wr_ptr] <= res_in;
  end

endmodule

// ===== design/triangle_edge_rasterizer_core.sv =====
// top level of the edge-function triangle rasterizer with its register port
// depends on: ter_pkg, ter_front, ter_back, ter_resq
//
// usage:
//   command items enter through push/full; command 0 loads three vertices and
//   sets up the bounding box and the signed area, command 1 steps one pixel
//   through the box in row order and yields one result item while a walk runs
//   results leave through empty/pop: pixel_x, pixel_y, covered, last_pixel
//   of the oldest item stay on the ports while empty is low
//   screen_width (0x0) and screen_height (0x4) must be written over the
//   register port only while the block is idle; the block does not enforce it
// flow:
//   in the back part a load or an advance has its edge products registered in
//   S_IDLE, then its sign tests and walk update in S_LOAD_FIN or S_ADV_FIN; a
//   dropped advance is only popped; new commands are taken only in S_IDLE
//   a degenerate triangle and an advance with no walk give no item
// reset and stalls:
//   reset empties both queues, ends any walk and restores 640 x 480
//   when the receiver stops popping, the result queue fills, the back part
//   holds advances, and full rises once the two command slots are taken
module triangle_edge_rasterizer_core
  import ter_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // command channel
  input  logic                     push,
  output logic                     full,
  input  logic                     command,
  input  coord_t                   vertex_a_x,
  input  coord_t                   vertex_a_y,
  input  coord_t                   vertex_b_x,
  input  coord_t                   vertex_b_y,
  input  coord_t                   vertex_c_x,
  input  coord_t                   vertex_c_y,
  // result channel
  output logic                     empty,
  input  logic                     pop,
  output coord_t                   pixel_x,
  output coord_t                   pixel_y,
  output logic                     covered,
  output logic                     last_pixel,
  // register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  screen_t  screen_width;
  screen_t  screen_height;
  reg_idx_t reg_sel;
  logic     cfg_wr;
  logic     cmd_valid;
  cmd_t     cmd;
  logic     cmd_pop;
  logic     res_push;
  logic     res_full;
  res_t     res_in;
  res_t     res_out;

  // register port
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_sel)
      REG_SCREEN_WIDTH:  prdata = CFG_DATA_BITS'(screen_width);
      REG_SCREEN_HEIGHT: prdata = CFG_DATA_BITS'(screen_height);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_BITS'(640);
      screen_height <= SCREEN_BITS'(480);
    end else if (cfg_wr) begin
      if (reg_sel == REG_SCREEN_WIDTH) screen_width <= pwdata[SCREEN_BITS-1:0];
      else                             screen_height <= pwdata[SCREEN_BITS-1:0];
    end
  end

  // front: accept and classify
  ter_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .command    (command),
    .vertex_a_x (vertex_a_x),
    .vertex_a_y (vertex_a_y),
    .vertex_b_x (vertex_b_x),
    .vertex_b_y (vertex_b_y),
    .vertex_c_x (vertex_c_x),
    .vertex_c_y (vertex_c_y),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  // back: setup and walk
  ter_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .res_full      (res_full),
    .res_push      (res_push),
    .res           (res_in)
  );

  // result queue
  ter_resq u_resq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_in   (res_in),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .res_out  (res_out)
  );

  assign pixel_x    = res_out.pixel_x;
  assign pixel_y    = res_out.pixel_y;
  assign covered    = res_out.covered;
  assign last_pixel = res_out.last_pixel;

endmodule
